/* rtl/bsws_pkg.sv */
// bsws_pkg: shared types and constants for the bounded stack with search
// no dependencies; used by the interfaces, controller, datapath and top level

package bsws_pkg;

   localparam int ACT_W     = 3;
   localparam int VALUE_W   = 32;
   localparam int CAP_W     = 7;
   localparam int CNT_OUT_W = 7;
   localparam int IDX_OUT_W = 6;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   // request action codes
   localparam logic [ACT_W-1:0] ACT_PUSH   = 3'd0;
   localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PEEK   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic accept;     // take the request beat and update the stack
      logic load_fin;   // result needs no memory data
      logic load_read;  // result carries the popped or peeked word
      logic load_srch;  // search finished at the current entry
      logic step;       // search moves one entry down
   } bsws_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic go_read;    // incoming pop or peek on a non-empty stack
      logic go_srch;    // incoming search on a non-empty stack
      logic match;      // entry under the search pointer equals the key
      logic scan_zero;  // search pointer at the bottom entry
      logic out_free;   // result register can take a new beat
   } bsws_stat_type;

endpackage

/* rtl/bsws_req_if.sv */
// bsws_req_if: request channel, valid/ready with action and value payload
// depends on bsws_pkg

interface bsws_req_if import bsws_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic [ACT_W-1:0]          action;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);

endinterface

/* rtl/bsws_rsp_if.sv */
// bsws_rsp_if: result channel, valid/ready with status payload
// depends on bsws_pkg

interface bsws_rsp_if import bsws_pkg::*; ();

   logic                      valid;
   logic                      ready;
   logic                      ok;
   logic signed [VALUE_W-1:0] read_value;
   logic [IDX_OUT_W-1:0]      found_index;
   logic [CNT_OUT_W-1:0]      count;
   logic                      is_empty;
   logic                      is_full;

   modport source (output valid, output ok, output read_value, output found_index,
                   output count, output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input read_value, input found_index,
                   input count, input is_empty, input is_full, output ready);

endinterface

/* rtl/bsws_ram.sv */
// bsws_ram: generic single-write, single-read RAM with registered read data
// no dependencies

module bsws_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bsws_ctrl.sv */
// bsws_ctrl: sequencing state machine for the stack
// depends on bsws_pkg; drives bsws_dp through bsws_cmd_type

module bsws_ctrl import bsws_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  bsws_stat_type stat,
   output bsws_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIN,
      ST_READ,
      ST_SRCH
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.go_read) begin
                  state_in = ST_READ;
               end else if (stat.go_srch) begin
                  state_in = ST_SRCH;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (stat.out_free) begin
               cmd.load_fin = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_READ: begin
            if (stat.out_free) begin
               cmd.load_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SRCH: begin
            if (stat.match || stat.scan_zero) begin
               if (stat.out_free) begin
                  cmd.load_srch = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

/* rtl/bsws_dp.sv */
// bsws_dp: stack datapath with count, capacity register, search pointer and result register
// depends on bsws_pkg, bsws_ram and bsws_rsp_if; commanded by bsws_ctrl

module bsws_dp import bsws_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bsws_cmd_type              cmd,
   output bsws_stat_type             stat,
   input  logic [ACT_W-1:0]          req_action,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic                      csr_we,
   input  logic [CAP_W-1:0]          csr_wdata,
   bsws_rsp_if.source                rsp
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int IDX_XW = (ADDR_W > IDX_OUT_W) ? ADDR_W : IDX_OUT_W;

   logic [CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic               okp_ff, okp_in;
   logic [VALUE_W-1:0] key_ff;

   logic                      out_valid_ff;
   logic                      out_ok_ff;
   logic signed [VALUE_W-1:0] out_read_ff;
   logic [IDX_OUT_W-1:0]      out_idx_ff;
   logic [CNT_OUT_W-1:0]      out_count_ff;
   logic                      out_empty_ff;
   logic                      out_full_ff;

   logic [LIM_W-1:0]   cap_x, depth_x, lim, cnt_x;
   logic [IDX_XW-1:0]  scan_x;
   logic               has_room, not_empty, out_free, match;
   logic [CNT_W-1:0]   cnt_dec;
   logic [ADDR_W-1:0]  top_addr, scan_dec;
   logic               ram_we, ram_re;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   // effective limit saturates at the storage depth
   assign cap_x     = LIM_W'(cap_ff);
   assign depth_x   = LIM_W'(DEPTH);
   assign lim       = (cap_x < depth_x) ? cap_x : depth_x;
   assign cnt_x     = LIM_W'(count_ff);
   assign has_room  = (cnt_x < lim);
   assign not_empty = (count_ff != '0);
   assign cnt_dec   = count_ff - 1'b1;
   assign top_addr  = cnt_dec[ADDR_W-1:0];
   assign scan_dec  = scan_ff - 1'b1;
   assign scan_x    = IDX_XW'(scan_ff);
   assign match     = (ram_rdata == key_ff);
   assign out_free  = !out_valid_ff || rsp.ready;

   always_comb begin
      count_in = count_ff;
      scan_in  = scan_ff;
      okp_in   = okp_ff;
      ram_we   = 1'b0;
      ram_re   = 1'b0;
      if (cmd.accept) begin
         okp_in = 1'b0;
         case (req_action)
            ACT_PUSH: begin
               if (has_room) begin
                  ram_we   = 1'b1;
                  count_in = count_ff + 1'b1;
                  okp_in   = 1'b1;
               end
            end
            ACT_POP: begin
               if (not_empty) begin
                  ram_re   = 1'b1;
                  count_in = cnt_dec;
                  okp_in   = 1'b1;
               end
            end
            ACT_PEEK: begin
               if (not_empty) begin
                  ram_re = 1'b1;
                  okp_in = 1'b1;
               end
            end
            ACT_CLEAR: begin
               count_in = '0;
               okp_in   = 1'b1;
            end
            ACT_SEARCH: begin
               if (not_empty) begin
                  ram_re  = 1'b1;
                  scan_in = top_addr;
               end
            end
            default: begin
               okp_in = 1'b0;
            end
         endcase
      end else if (cmd.step) begin
         ram_re  = 1'b1;
         scan_in = scan_dec;
      end
   end

   assign ram_raddr = cmd.step ? scan_dec : top_addr;

   bsws_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[ADDR_W-1:0]),
      .wdata (req_value),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      stat.go_read   = ((req_action == ACT_POP) || (req_action == ACT_PEEK)) && not_empty;
      stat.go_srch   = (req_action == ACT_SEARCH) && not_empty;
      stat.match     = match;
      stat.scan_zero = (scan_ff == '0);
      stat.out_free  = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
         count_ff <= count_in;
         if (cmd.load_fin || cmd.load_read || cmd.load_srch) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      okp_ff  <= okp_in;
      if (cmd.accept) begin
         key_ff <= req_value;
      end
      if (cmd.load_fin || cmd.load_read || cmd.load_srch) begin
         out_count_ff <= cnt_x[CNT_OUT_W-1:0];
         out_empty_ff <= !not_empty;
         out_full_ff  <= !has_room;
         out_ok_ff    <= (cmd.load_fin && okp_ff) || cmd.load_read ||
                         (cmd.load_srch && match);
         out_read_ff  <= cmd.load_read ? $signed(ram_rdata) : '0;
         out_idx_ff   <= (cmd.load_srch && match) ? scan_x[IDX_OUT_W-1:0] : '0;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.ok          = out_ok_ff;
   assign rsp.read_value  = out_read_ff;
   assign rsp.found_index = out_idx_ff;
   assign rsp.count       = out_count_ff;
   assign rsp.is_empty    = out_empty_ff;
   assign rsp.is_full     = out_full_ff;

endmodule

/* rtl/bounded_stack_with_search.sv */
// bounded_stack_with_search: top level, LIFO of signed words with capacity limit and search
// push, pop, peek, clear, unused codes, empty-stack search: accept, then load the result
// search of k stored entries: top down, one ram read each, until a match or the bottom
// one request at a time; the result register lets the next request in while a beat waits
// synchronous active-high reset: stack empty, capacity 64, storage contents left as is
// depends on bsws_pkg, bsws_req_if, bsws_rsp_if, bsws_ctrl, bsws_dp

module bounded_stack_with_search import bsws_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   bsws_req_if.sink         req_ch,
   bsws_rsp_if.source       rsp_ch,
   input  logic             csr_we,
   input  logic [CAP_W-1:0] csr_wdata
);

   bsws_cmd_type  cmd;
   bsws_stat_type stat;
   logic          req_ready;

   bsws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   bsws_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_action (req_ch.action),
      .req_value  (req_ch.value),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp        (rsp_ch)
   );

   assign req_ch.ready = req_ready;

endmodule
